// ===== sv/kpd_pkg.sv =====
// Shared types and constants for the keypad press/release debouncer.
// No dependencies; imported by every module of the block.
package kpd_pkg;

    localparam int unsigned KPD_TIME_BITS = 32;
    localparam logic [15:0] MIN_HOLD_RESET = 16'd50;
    localparam logic [4:0]  NO_KEY = 5'd16;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] kind;
        logic [4:0] key;
        logic [7:0] ch;
    } result_t;

endpackage

// ===== sv/kpd_fsm.sv =====
// Six-phase press/release qualifier: state registers and next-state logic.
// Depends on kpd_pkg.
module kpd_fsm #(
    parameter int unsigned TIME_BITS = kpd_pkg::KPD_TIME_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic             pressed_now,
    input  logic             key_decoded,
    input  logic [3:0]       scan_code,
    input  logic [7:0]       scan_char,
    input  logic [31:0]      now_ms,
    input  logic [15:0]      min_hold,
    output kpd_pkg::result_t result
);
    import kpd_pkg::*;

    localparam int unsigned NOW_W = (TIME_BITS < 32) ? TIME_BITS : 32;
    localparam int unsigned CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_MAYBE_PRESS = 3'd1,
        PH_PRESS_OK    = 3'd2,
        PH_HELD        = 3'd3,
        PH_MAYBE_REL   = 3'd4,
        PH_REL_OK      = 3'd5
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [TIME_BITS-1:0]   mark_reg, mark_next;
    logic [4:0]             key_reg, key_next;
    logic [7:0]             char_reg, char_next;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   hold_met;

    assign now_t    = TIME_BITS'(now_ms[NOW_W-1:0]);
    assign elapsed  = now_t - mark_reg;
    assign hold_met = CMP_W'(elapsed) >= CMP_W'(min_hold);

    always_comb begin
        phase_next   = phase_reg;
        mark_next    = mark_reg;
        key_next     = key_reg;
        char_next    = char_reg;
        result.kind  = EV_NONE;
        result.key   = NO_KEY;
        result.ch    = 8'd0;
        case (phase_reg)
            PH_MAYBE_PRESS: begin
                if (!pressed_now) begin
                    phase_next = PH_IDLE;
                end else if (hold_met) begin
                    phase_next = PH_PRESS_OK;
                end
            end
            PH_PRESS_OK: begin
                result.kind = EV_PRESS;
                result.key  = key_reg;
                result.ch   = char_reg;
                phase_next  = PH_HELD;
            end
            PH_HELD: begin
                if (!pressed_now) begin
                    mark_next  = now_t;
                    phase_next = PH_MAYBE_REL;
                end
            end
            PH_MAYBE_REL: begin
                if (pressed_now) begin
                    phase_next = PH_HELD;
                end else if (hold_met) begin
                    phase_next = PH_REL_OK;
                end
            end
            PH_REL_OK: begin
                key_next    = NO_KEY;
                result.kind = EV_RELEASE;
                result.ch   = char_reg;
                phase_next  = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
                if (pressed_now && key_decoded) begin
                    mark_next  = now_t;
                    key_next   = {1'b0, scan_code};
                    char_next  = scan_char;
                    phase_next = PH_MAYBE_PRESS;
                end
            end
        endcase
        result.phase = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            mark_reg  <= '0;
            key_reg   <= NO_KEY;
            char_reg  <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            mark_reg  <= mark_next;
            key_reg   <= key_next;
            char_reg  <= char_next;
        end
    end

    a_press_then_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_PRESS_OK) |=> phase_reg == PH_HELD)
        else $error("press event not followed by held phase");

    a_release_clears_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_reg == PH_REL_OK) |=> (key_reg == NO_KEY && phase_reg == PH_IDLE))
        else $error("release did not clear latched key");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ($stable(phase_reg) && $stable(mark_reg) && $stable(key_reg)))
        else $error("state changed without a transaction");

endmodule

// ===== sv/kpd_skid.sv =====
// Result register with skid stage between the qualifier and the output channel.
// Depends on kpd_pkg.
module kpd_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  kpd_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output kpd_pkg::result_t out_data
);
    import kpd_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    a_skid_implies_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> (main_valid_reg && main_reg == $past(skid_reg)))
        else $error("skid entry lost on output transaction");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !main_valid_reg) |=> (main_valid_reg && main_reg == $past(in_data)))
        else $error("accepted result not captured");

endmodule

// ===== sv/keypad_press_release_debouncer_core.sv =====
// Keypad press/release debouncer, top level: stream ports, hold-time register.
// Depends on kpd_pkg, kpd_fsm and kpd_skid.
//
// One poll enters per clock while s_tready is high, and its result is held in
// the output register; the qualifier is a single subtract and compare on the
// timestamp, and a two-entry output register lets polls keep flowing while a
// result waits. Each accepted poll yields exactly one result: the phase after
// the poll and, when a press or release has persisted for min_hold_ms, the
// event with the character latched at the start of the press and, for a press,
// its key code. Timestamps are taken modulo 2^TIME_BITS. The hold register is
// written through cfg_* and should only change while no poll is in flight.
module keypad_press_release_debouncer_core #(
    parameter int unsigned TIME_BITS = kpd_pkg::KPD_TIME_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pressed_now, scan_code[3:0], scan_char[7:0], now_ms[31:0]
    input  logic [0:0]  s_tuser,   // key_decoded
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // phase_out[2:0], event_key[4:0], event_char[7:0]
    output logic [1:0]  m_tuser,   // event_kind[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // min_hold_ms
);
    import kpd_pkg::*;

    logic [15:0] min_hold_reg;
    logic        accept;
    result_t     fsm_result;
    result_t     out_result;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_hold_reg <= MIN_HOLD_RESET;
        end else if (cfg_valid) begin
            min_hold_reg <= cfg_data;
        end
    end

    kpd_fsm #(
        .TIME_BITS(TIME_BITS)
    ) u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .pressed_now (s_tdata[0]),
        .key_decoded (s_tuser[0]),
        .scan_code   (s_tdata[4:1]),
        .scan_char   (s_tdata[12:5]),
        .now_ms      (s_tdata[44:13]),
        .min_hold    (min_hold_reg),
        .result      (fsm_result)
    );

    kpd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (fsm_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.ch, out_result.key, out_result.phase};
    assign m_tuser = out_result.kind;

endmodule
